// File: design/ccsc_pkg.sv
// Shared types and constants for the COO to CSC converter.
// Depends on nothing; every other file of the block imports it.
package ccsc_pkg;

  // Fixed field widths of the command and result ports.
  localparam int CMD_W = 2;
  localparam int ROW_W = 16;
  localparam int COL_W = 5;
  localparam int VAL_W = 64;
  localparam int PTR_W = 6;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_ENTRIES = 32;
  localparam int DEF_MAX_COLS    = 31;
  localparam int DEF_ROW_BITS    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD        = 2'd0,
    CMD_LOAD_FINISH = 2'd1,
    CMD_FINISH      = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_ENTRY   = 1'b0,
    KIND_POINTER = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD_I,
    ST_HOLD,
    ST_CMP,
    ST_WR,
    ST_E_RD,
    ST_E_OUT,
    ST_P_RD,
    ST_P_CMP,
    ST_FINAL
  } state_e;

endpackage

// File: design/coo_to_csc_converter_unit.sv
// Top level of the COO to CSC converter: command port, entry store, rank sort,
// sorted store and result sequencer. Depends on ccsc_pkg and ccsc_order_cmp.
//
// Usage. Commands enter on start_i and are taken at a clock edge where start_i
// is high and busy_o is low. A load (cmd 0) writes one triplet into the entry
// store as it is taken and busy_o stays low. A finish (cmd 1 loads and then
// finishes, cmd 2 only finishes) raises busy_o until the whole run has been
// emitted. Command code 3 is taken and ignored.
// Results leave at most one beat per cycle, marked by result_valid_o for exactly
// one cycle; the receiver cannot stall them. First come the n sorted entries
// (kind 0, back to back), then num_cols+1 column pointers (kind 1), the last
// one carrying last_o and equal to n. An empty finish emits nothing.
// Entries whose column is at or beyond num_cols, or that arrive with the store
// full, are dropped and overflow_o is set on every beat of that run.
// A finish with n stored entries runs a start step, then a rank pass paced by
// the single read port of the entry store, which streams every entry past each
// held entry once, then emits the sorted entries and at last walks the sorted
// store to emit the column pointers.
// Num_cols is written on the cfg channel, which is always ready; writes above
// MAX_COLS saturate. Reset clears the entry count, the dropped flag and the
// sequencer and sets num_cols to MAX_COLS; the stores need no clearing.
module coo_to_csc_converter_unit import ccsc_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int ROW_BITS    = DEF_ROW_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Command channel.
  input  logic             start_i,
  output logic             busy_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [ROW_W-1:0] entry_row_i,
  input  logic [COL_W-1:0] entry_col_i,
  input  logic [VAL_W-1:0] entry_value_i,
  // Configuration channel for num_cols.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [COL_W-1:0] cfg_data_i,
  // Result channel.
  output logic             result_valid_o,
  output logic             kind_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [VAL_W-1:0] out_value_o,
  output logic [PTR_W-1:0] col_pointer_o,
  output logic             overflow_o,
  output logic             last_o
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = COL_W + ROW_BITS + VAL_W;

  // Entry word layout: {column, row, value}.
  localparam int ROW_LO = VAL_W;
  localparam int COL_LO = VAL_W + ROW_BITS;

  state_e state_q, state_d;

  logic [COL_W-1:0] num_cols_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] rank_q, rank_d;
  logic [CNT_W-1:0] p_q, p_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [COL_W-1:0] c_q, c_d;
  logic [ENT_W-1:0] hold_q, hold_d;

  // Entry store in load order, and sorted store in rank order.
  logic [ENT_W-1:0] st_mem [MAX_ENTRIES];
  logic [ENT_W-1:0] st_rdata_q, st_wdata;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  logic             st_we, st_re;

  logic [ENT_W-1:0] so_mem [MAX_ENTRIES];
  logic [ENT_W-1:0] so_rdata_q;
  logic [IDX_W-1:0] so_waddr, so_raddr;
  logic             so_we, so_re;

  logic [IDX_W-1:0] jr;
  logic             ahead;

  // Streamed entry j-1 goes before the held entry i: it raises i's rank.
  assign jr = IDX_W'(j_q - 1'b1);

  ccsc_order_cmp #(
    .ROW_BITS (ROW_BITS),
    .IDX_W    (IDX_W)
  ) u_cmp (
    .a_ent_i  (st_rdata_q),
    .a_idx_i  (jr),
    .b_ent_i  (hold_q),
    .b_idx_i  (i_q[IDX_W-1:0]),
    .before_o (ahead)
  );

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (so_we) begin
      so_mem[so_waddr] <= hold_q;
    end
    if (so_re) begin
      so_rdata_q <= so_mem[so_raddr];
    end
  end

  // Configuration register; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= COL_W'(MAX_COLS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i > COL_W'(MAX_COLS)) begin
        num_cols_q <= COL_W'(MAX_COLS);
      end else begin
        num_cols_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
      p_q     <= '0;
      pos_q   <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rank_q  <= rank_d;
      p_q     <= p_d;
      pos_q   <= pos_d;
      c_q     <= c_d;
    end
  end

  // The held entry is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign overflow_o = drop_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    i_d      = i_q;
    j_d      = j_q;
    rank_d   = rank_q;
    p_d      = p_q;
    pos_d    = pos_q;
    c_d      = c_q;
    hold_d   = hold_q;
    st_we    = 1'b0;
    st_waddr = cnt_q[IDX_W-1:0];
    st_wdata = {entry_col_i, ROW_BITS'(entry_row_i), entry_value_i};
    st_re    = 1'b0;
    st_raddr = '0;
    so_we    = 1'b0;
    so_waddr = rank_q[IDX_W-1:0];
    so_re    = 1'b0;
    so_raddr = '0;

    result_valid_o = 1'b0;
    kind_o         = KIND_ENTRY;
    out_row_o      = '0;
    out_value_o    = '0;
    col_pointer_o  = '0;
    last_o         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(cmd_i))
            CMD_LOAD, CMD_LOAD_FINISH: begin
              if ((entry_col_i >= num_cols_q) || (cnt_q >= CNT_W'(MAX_ENTRIES))) begin
                drop_d = 1'b1;
              end else begin
                st_we = 1'b1;
                cnt_d = cnt_q + 1'b1;
              end
              if (cmd_e'(cmd_i) == CMD_LOAD_FINISH) begin
                state_d = ST_START;
              end
            end
            CMD_FINISH: begin
              state_d = ST_START;
            end
            default: begin
            end
          endcase
        end
      end

      ST_START: begin
        if (cnt_q == '0) begin
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          i_d     = '0;
          state_d = ST_RD_I;
        end
      end

      ST_RD_I: begin
        st_re    = 1'b1;
        st_raddr = i_q[IDX_W-1:0];
        state_d  = ST_HOLD;
      end

      ST_HOLD: begin
        hold_d   = st_rdata_q;
        st_re    = 1'b1;
        st_raddr = '0;
        j_d      = CNT_W'(1);
        rank_d   = '0;
        state_d  = ST_CMP;
      end

      ST_CMP: begin
        if (ahead) begin
          rank_d = rank_q + 1'b1;
        end
        if (j_q < cnt_q) begin
          st_re    = 1'b1;
          st_raddr = j_q[IDX_W-1:0];
          j_d      = j_q + 1'b1;
        end else begin
          state_d = ST_WR;
        end
      end

      ST_WR: begin
        so_we = 1'b1;
        if (i_q == cnt_q - 1'b1) begin
          state_d = ST_E_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_RD_I;
        end
      end

      ST_E_RD: begin
        so_re    = 1'b1;
        so_raddr = '0;
        p_d      = CNT_W'(1);
        state_d  = ST_E_OUT;
      end

      ST_E_OUT: begin
        result_valid_o = 1'b1;
        kind_o         = KIND_ENTRY;
        out_row_o      = ROW_W'(so_rdata_q[COL_LO-1:ROW_LO]);
        out_value_o    = so_rdata_q[VAL_W-1:0];
        if (p_q < cnt_q) begin
          so_re    = 1'b1;
          so_raddr = p_q[IDX_W-1:0];
          p_d      = p_q + 1'b1;
        end else begin
          c_d     = '0;
          pos_d   = '0;
          state_d = ST_P_RD;
        end
      end

      // Pointer c is the first sorted position whose column is at least c.
      ST_P_RD: begin
        if (c_q == num_cols_q) begin
          state_d = ST_FINAL;
        end else if (pos_q < cnt_q) begin
          so_re    = 1'b1;
          so_raddr = pos_q[IDX_W-1:0];
          state_d  = ST_P_CMP;
        end else begin
          result_valid_o = 1'b1;
          kind_o         = KIND_POINTER;
          col_pointer_o  = PTR_W'(pos_q);
          c_d            = c_q + 1'b1;
        end
      end

      ST_P_CMP: begin
        if (so_rdata_q[ENT_W-1:COL_LO] < c_q) begin
          pos_d = pos_q + 1'b1;
        end else begin
          result_valid_o = 1'b1;
          kind_o         = KIND_POINTER;
          col_pointer_o  = PTR_W'(pos_q);
          c_d            = c_q + 1'b1;
        end
        state_d = ST_P_RD;
      end

      ST_FINAL: begin
        result_valid_o = 1'b1;
        kind_o         = KIND_POINTER;
        col_pointer_o  = PTR_W'(cnt_q);
        last_o         = 1'b1;
        cnt_d          = '0;
        drop_d         = 1'b0;
        state_d        = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Results appear only inside a finish run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result beat outside a finish run");

  // The final beat is a pointer equal to the entry count, and ends the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> (!busy_o && (cnt_q == '0)))
    else $error("run did not end after the last beat");

  // Ranks written into the sorted store lie inside the stored set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> (rank_q < cnt_q))
    else $error("rank outside the stored entries");

  // The pointer walk never runs past the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P_RD) |-> (pos_q <= cnt_q))
    else $error("pointer position beyond entry count");

endmodule

// File: design/ccsc_order_cmp.sv
// Sort-order comparator: column, then row, then value in IEEE total order.
// Depends on ccsc_pkg for the value and column widths.
module ccsc_order_cmp import ccsc_pkg::*; #(
  parameter int ROW_BITS = DEF_ROW_BITS,
  parameter int IDX_W    = 5
) (
  input  logic [COL_W+ROW_BITS+VAL_W-1:0] a_ent_i,
  input  logic [IDX_W-1:0]                a_idx_i,
  input  logic [COL_W+ROW_BITS+VAL_W-1:0] b_ent_i,
  input  logic [IDX_W-1:0]                b_idx_i,
  output logic                            before_o
);

  localparam int ENT_W = COL_W + ROW_BITS + VAL_W;

  logic [VAL_W-1:0] a_val, b_val, a_ord, b_ord;
  logic [ENT_W-1:0] a_word, b_word;

  // Map the double's bit pattern onto an unsigned order: negatives are
  // inverted, positives get their sign bit set.
  always_comb begin
    a_val = a_ent_i[VAL_W-1:0];
    b_val = b_ent_i[VAL_W-1:0];
    a_ord = a_val[VAL_W-1] ? ~a_val : {1'b1, a_val[VAL_W-2:0]};
    b_ord = b_val[VAL_W-1] ? ~b_val : {1'b1, b_val[VAL_W-2:0]};
    a_word = {a_ent_i[ENT_W-1:VAL_W], a_ord};
    b_word = {b_ent_i[ENT_W-1:VAL_W], b_ord};
    // Equal entries are ranked by store position so that ranks are unique.
    before_o = (a_word < b_word) || ((a_word == b_word) && (a_idx_i < b_idx_i));
  end

endmodule
